>>> src/erot_pkg.sv
// Package: shared types and constants for the Euler XYZ vector rotator.
`timescale 1ns / 1ps
package erot_pkg;

  localparam int COORD_W      = 32;
  localparam int ANGLE_W      = 16;
  localparam int ANGLE_FRAC   = 6;
  localparam int DEG_FRAC     = 16;
  localparam int TRIG_FRAC    = 30;
  localparam int CORDIC_STEPS = 22;
  localparam int TRIG_W       = 33;
  localparam int ZW           = 26;
  localparam int RED_W        = ANGLE_W + 2;
  localparam int PROD_W       = COORD_W + TRIG_W;
  localparam int ACC_W        = PROD_W + 1;

  localparam int FULL_IN      = 360 << ANGLE_FRAC;
  localparam int HALF_IN      = 180 << ANGLE_FRAC;
  localparam int HALF_DEG     = 180 << DEG_FRAC;
  localparam int QUARTER_DEG  = 90 << DEG_FRAC;
  localparam int CORDIC_GAIN  = 652032874;

  localparam int ATAN_DEG [0:CORDIC_STEPS-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [ZW-1:0]     z;
  } cordic_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

endpackage

>>> src/erot_if.sv
// Interfaces: input and output channels of the Euler XYZ vector rotator.
`timescale 1ns / 1ps
interface erot_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [erot_pkg::COORD_W-1:0]   in_x;
  logic signed [erot_pkg::COORD_W-1:0]   in_y;
  logic signed [erot_pkg::COORD_W-1:0]   in_z;
  logic signed [erot_pkg::ANGLE_W-1:0]   angle_x;
  logic signed [erot_pkg::ANGLE_W-1:0]   angle_y;
  logic signed [erot_pkg::ANGLE_W-1:0]   angle_z;
  modport source (output valid, in_x, in_y, in_z, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, in_x, in_y, in_z, angle_x, angle_y, angle_z, output ready);
endinterface

interface erot_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [erot_pkg::COORD_W-1:0]   out_x;
  logic signed [erot_pkg::COORD_W-1:0]   out_y;
  logic signed [erot_pkg::COORD_W-1:0]   out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

>>> src/euler_xyz_vector_rotator.sv
// Top level: pipelined Euler XYZ rotation of a Q16.16 vector.
//
//   channel | dir | payload                                    | transfer
//   vin     | in  | in_x, in_y, in_z, angle_x, angle_y, angle_z | valid && ready
//   vout    | out | out_x, out_y, out_z                        | valid && ready
//
// One vector per cycle when not stalled: angle reduction, 22 CORDIC
// steps (one per stage, three axes side by side), sign fix, then a
// multiply stage and a sum/round/saturate stage for each of X, Y and Z.
// Synchronous reset clears the valid bits only.
// A stall at the output freezes every stage at once; nothing is dropped.
`timescale 1ns / 1ps
module euler_xyz_vector_rotator (
  input  logic        clk,
  input  logic        rst,
  erot_in_if.sink     vin,
  erot_out_if.source  vout
);

  localparam int NCS = erot_pkg::CORDIC_STEPS;
  localparam int NST = NCS + 8;

  logic           en;
  logic [NST-1:0] vld;

  erot_pkg::vec_t    crd  [0:NCS];
  erot_pkg::cordic_t cs   [0:NCS][0:2];
  logic [2:0]        neg  [0:NCS];
  logic [2:0]        zr   [0:NCS];

  erot_pkg::vec_t    rv   [0:3];
  erot_pkg::trig_t   trg  [0:3][0:2];
  logic [2:0]        rzr  [0:3];

  function automatic logic signed [erot_pkg::RED_W-1:0] reduce(
    input logic signed [erot_pkg::ANGLE_W-1:0] a
  );
    logic signed [erot_pkg::RED_W-1:0] t;
    t = erot_pkg::RED_W'(a) + erot_pkg::RED_W'(2 * erot_pkg::FULL_IN);
    if (t >= erot_pkg::RED_W'(2 * erot_pkg::FULL_IN)) begin
      t = t - erot_pkg::RED_W'(2 * erot_pkg::FULL_IN);
    end
    if (t >= erot_pkg::RED_W'(erot_pkg::FULL_IN)) begin
      t = t - erot_pkg::RED_W'(erot_pkg::FULL_IN);
    end
    if (t > erot_pkg::RED_W'(erot_pkg::HALF_IN)) begin
      t = t - erot_pkg::RED_W'(erot_pkg::FULL_IN);
    end
    return t;
  endfunction

  function automatic erot_pkg::cordic_t cstep(input erot_pkg::cordic_t c, input int i);
    erot_pkg::cordic_t          n;
    logic signed [erot_pkg::TRIG_W-1:0] dx;
    logic signed [erot_pkg::TRIG_W-1:0] dy;
    logic signed [erot_pkg::ZW-1:0]     at;
    dx = c.y >>> i;
    dy = c.x >>> i;
    at = erot_pkg::ZW'(erot_pkg::ATAN_DEG[i]);
    if (c.z >= 0) begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - at;
    end else begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + at;
    end
    return n;
  endfunction

  function automatic logic signed [erot_pkg::COORD_W-1:0] rnd_sat(
    input logic signed [erot_pkg::ACC_W-1:0] acc
  );
    logic signed [erot_pkg::ACC_W-1:0] sh;
    sh = (acc + erot_pkg::ACC_W'(64'sd1 <<< (erot_pkg::TRIG_FRAC - 1)))
         >>> erot_pkg::TRIG_FRAC;
    if (sh > erot_pkg::ACC_W'(64'sd2147483647)) begin
      return erot_pkg::COORD_W'(32'h7fffffff);
    end else if (sh < -erot_pkg::ACC_W'(64'sd2147483648)) begin
      return erot_pkg::COORD_W'(32'h80000000);
    end
    return sh[erot_pkg::COORD_W-1:0];
  endfunction

  assign en        = !vld[NST-1] || vout.ready;
  assign vin.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], vin.valid};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [erot_pkg::RED_W-1:0] r;
    logic signed [erot_pkg::ZW-1:0]    z;
    logic signed [erot_pkg::ANGLE_W-1:0] ang [0:2];
    if (en) begin
      ang[0] = vin.angle_x;
      ang[1] = vin.angle_y;
      ang[2] = vin.angle_z;
      crd[0] <= '{x: vin.in_x, y: vin.in_y, z: vin.in_z};
      for (int a = 0; a < 3; a++) begin
        r = reduce(ang[a]);
        z = erot_pkg::ZW'(r) <<< (erot_pkg::DEG_FRAC - erot_pkg::ANGLE_FRAC);
        zr[0][a] <= (r == '0);
        if (z > erot_pkg::ZW'(erot_pkg::QUARTER_DEG)) begin
          z = z - erot_pkg::ZW'(erot_pkg::HALF_DEG);
          neg[0][a] <= 1'b1;
        end else if (z < -erot_pkg::ZW'(erot_pkg::QUARTER_DEG)) begin
          z = z + erot_pkg::ZW'(erot_pkg::HALF_DEG);
          neg[0][a] <= 1'b1;
        end else begin
          neg[0][a] <= 1'b0;
        end
        cs[0][a] <= '{x: erot_pkg::TRIG_W'(erot_pkg::CORDIC_GAIN), y: '0, z: z};
      end
    end
  end

  for (genvar k = 0; k < NCS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        crd[k+1] <= crd[k];
        zr[k+1]  <= zr[k];
        neg[k+1] <= neg[k];
        for (int a = 0; a < 3; a++) begin
          cs[k+1][a] <= cstep(cs[k][a], k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rv[0]  <= crd[NCS];
      rzr[0] <= zr[NCS];
      for (int a = 0; a < 3; a++) begin
        trg[0][a].c <= neg[NCS][a] ? -cs[NCS][a].x : cs[NCS][a].x;
        if (a == 0) begin
          trg[0][a].s <= neg[NCS][a] ? cs[NCS][a].y : -cs[NCS][a].y;
        end else begin
          trg[0][a].s <= neg[NCS][a] ? -cs[NCS][a].y : cs[NCS][a].y;
        end
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_rot
    logic signed [erot_pkg::COORD_W-1:0] u;
    logic signed [erot_pkg::COORD_W-1:0] v;
    logic signed [erot_pkg::PROD_W-1:0]  p_uc, p_vs, p_us, p_vc;
    erot_pkg::vec_t                      mv;
    erot_pkg::trig_t                     mt [0:2];
    logic [2:0]                          mz;
    logic signed [erot_pkg::COORD_W-1:0] nu;
    logic signed [erot_pkg::COORD_W-1:0] nv;

    assign u = (r == 0) ? rv[r].y : rv[r].x;
    assign v = (r == 2) ? rv[r].y : rv[r].z;

    always_ff @(posedge clk) begin
      if (en) begin
        p_uc <= u * trg[r][r].c;
        p_vs <= v * trg[r][r].s;
        p_us <= u * trg[r][r].s;
        p_vc <= v * trg[r][r].c;
        mv   <= rv[r];
        mt   <= trg[r];
        mz   <= rzr[r];
      end
    end

    assign nu = rnd_sat(erot_pkg::ACC_W'(p_uc) - erot_pkg::ACC_W'(p_vs));
    assign nv = rnd_sat(erot_pkg::ACC_W'(p_us) + erot_pkg::ACC_W'(p_vc));

    always_ff @(posedge clk) begin
      erot_pkg::vec_t w;
      if (en) begin
        w = mv;
        if (!mz[r]) begin
          case (r)
            0: begin
              w.y = nu;
              w.z = nv;
            end
            1: begin
              w.x = nu;
              w.z = nv;
            end
            default: begin
              w.x = nu;
              w.y = nv;
            end
          endcase
        end
        trg[r+1] <= mt;
        rzr[r+1] <= mz;
        rv[r+1]  <= w;
      end
    end
  end

  assign vout.valid = vld[NST-1];
  assign vout.out_x = rv[3].x;
  assign vout.out_y = rv[3].y;
  assign vout.out_z = rv[3].z;

endmodule

>>> src/erot_chk.sv
// Checker: port-level assertions for the Euler XYZ vector rotator, with bind.
`timescale 1ns / 1ps
module erot_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with free output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind euler_xyz_vector_rotator erot_chk u_erot_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (vin.ready),
  .out_valid (vout.valid),
  .out_ready (vout.ready),
  .out_x     (vout.out_x),
  .out_y     (vout.out_y),
  .out_z     (vout.out_z)
);

>>> verif/euler_xyz_vector_rotator_test.sv
// Testbench: streams random and directed vectors through the rotator and checks each result.
`timescale 1ns / 1ps
module euler_xyz_vector_rotator_test;

  typedef struct packed {
    logic signed [erot_pkg::COORD_W-1:0] x;
    logic signed [erot_pkg::COORD_W-1:0] y;
    logic signed [erot_pkg::COORD_W-1:0] z;
    logic signed [erot_pkg::ANGLE_W-1:0] ax;
    logic signed [erot_pkg::ANGLE_W-1:0] ay;
    logic signed [erot_pkg::ANGLE_W-1:0] az;
  } rot_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  erot_in_if  vin();
  erot_out_if vout();

  euler_xyz_vector_rotator i_dut (.clk(clk), .rst(rst), .vin(vin), .vout(vout));

  always #5 clk = ~clk;

  rot_req_t       pending_reqs[$];
  erot_pkg::vec_t expected_vecs[$];
  int       n_errors = 0;
  int       cycle_cnt = 0;
  bit       stim_done = 0;
  bit       drain_pause = 0;
  int       hold_cycles = 0;
  int       burst_left = 0;
  int       gap_left = 0;

  function automatic longint wrap_angle(longint a);
    longint r;
    r = a % erot_pkg::FULL_IN;
    if (r < 0) r += erot_pkg::FULL_IN;
    if (r > erot_pkg::HALF_IN) r -= erot_pkg::FULL_IN;
    return r;
  endfunction

  function automatic void cordic_sin_cos(longint r, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit neg;
    z = r * (longint'(1) << (erot_pkg::DEG_FRAC - erot_pkg::ANGLE_FRAC));
    neg = 0;
    x = erot_pkg::CORDIC_GAIN;
    y = 0;
    if (z > erot_pkg::QUARTER_DEG) begin
      z -= erot_pkg::HALF_DEG;
      neg = 1;
    end else if (z < -erot_pkg::QUARTER_DEG) begin
      z += erot_pkg::HALF_DEG;
      neg = 1;
    end
    for (int i = 0; i < erot_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= erot_pkg::ATAN_DEG[i];
      end else begin
        x += dx; y -= dy; z += erot_pkg::ATAN_DEG[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint round_sat(longint a, longint p, longint b, longint q);
    longint acc;
    acc = a * p - b * q;
    acc = (acc + (longint'(1) << (erot_pkg::TRIG_FRAC - 1))) >>> erot_pkg::TRIG_FRAC;
    if (acc > 64'sd2147483647) return 64'sd2147483647;
    if (acc < -64'sd2147483648) return -64'sd2147483648;
    return acc;
  endfunction

  function automatic void turn_pair(inout longint u, inout longint v, input longint s,
                                    input longint c);
    longint nu, nv;
    nu = round_sat(u, c, v, s);
    nv = round_sat(u, s, v, -c);
    u = nu;
    v = nv;
  endfunction

  function automatic erot_pkg::vec_t rotate_xyz(rot_req_t r);
    longint x, y, z, a, s, c;
    erot_pkg::vec_t v;
    x = r.x; y = r.y; z = r.z;
    a = wrap_angle(longint'(r.ax));
    if (a != 0) begin
      cordic_sin_cos(a, s, c);
      turn_pair(y, z, -s, c);
    end
    a = wrap_angle(longint'(r.ay));
    if (a != 0) begin
      cordic_sin_cos(a, s, c);
      turn_pair(x, z, s, c);
    end
    a = wrap_angle(longint'(r.az));
    if (a != 0) begin
      cordic_sin_cos(a, s, c);
      turn_pair(x, y, s, c);
    end
    v.x = x[31:0]; v.y = y[31:0]; v.z = z[31:0];
    return v;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom_range(0, 1) ? 32'h7fff0000 + $urandom_range(0, 65535)
                                     : 32'h80000000 + $urandom_range(0, 65535);
      2: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20) : -$urandom_range(0, 1 << 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'sd0;
      1: return 16'(($urandom_range(0, 2) * 2 - 2) * 360 * 64);
      2: return 16'(($urandom_range(0, 1) ? 1 : -1) * 90 * 64 * $urandom_range(0, 4));
      3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      4: return 16'(180 * 64 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_req(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    rot_req_t r;
    r.x = x; r.y = y; r.z = z; r.ax = ax; r.ay = ay; r.az = az;
    pending_reqs.push_back(r);
  endtask

  initial begin
    push_req(32'h00010000, 32'h00020000, 32'h00030000, 16'd0, 16'd0, 16'd0);
    push_req(32'h00010000, 32'h00020000, 32'h00030000, 16'd5760, 16'd0, 16'd0);
    push_req(32'h00010000, 32'h00020000, 32'h00030000, 16'd0, 16'd5760, 16'd0);
    push_req(32'h00010000, 32'h00020000, 32'h00030000, 16'd0, 16'd0, 16'd5760);
    push_req(32'h00010000, 32'h00020000, 32'h00030000, 16'd23040, -16'sd23040, 16'd0);
    push_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'd2880, 16'd2880, 16'd2880);
    push_req(32'h80000000, 32'h80000000, 32'h80000000, 16'd2880, 16'd2880, 16'd2880);
    push_req(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h7fff, 16'h8000, 16'h7fff);
    push_req(32'h80000000, 32'h7fffffff, 32'h80000000, 16'd11520, -16'sd11520, 16'd11521);
    push_req(32'hffffffff, 32'h00000001, 32'h0, 16'd11519, -16'sd5760, -16'sd1);
    push_req(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 16'd1, 16'd1, 16'd1);
    push_req(32'h7fffffff, 32'h0, 32'h80000000, -16'sd5759, 16'd5761, 16'd17280);
    push_req(32'h55555555, 32'haaaaaaaa, 32'hffffffff, 16'h5555, 16'haaaa, 16'hffff);
    for (int i = 0; i < 1500; i++)
      push_req(rand_coord(), rand_coord(), rand_coord(), rand_angle(), rand_angle(),
               rand_angle());
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == 1) rst <= 1'b0;
  end

  initial begin
    vin.valid = 1'b0;
    vin.in_x = '0; vin.in_y = '0; vin.in_z = '0;
    vin.angle_x = '0; vin.angle_y = '0; vin.angle_z = '0;
    vout.ready = 1'b0;
  end

  // sender: bursts with gaps, one full drain pause mid-run
  always @(posedge clk) begin
    bit acc;
    acc = vin.valid && vin.ready;
    if (!rst) begin
      if (acc) begin
        expected_vecs.push_back(rotate_xyz(pending_reqs.pop_front()));
        if (pending_reqs.size() == 700) drain_pause <= 1'b1;
      end
      if (drain_pause && expected_vecs.size() == 0 && !acc)
        drain_pause <= 1'b0;
      if (vin.valid && !vin.ready) begin
        // hold the offered item
      end else if (pending_reqs.size() > 0 && !drain_pause
                   && !(acc && pending_reqs.size() == 700)
                   && (burst_left > 0 || gap_left == 0)) begin
        vin.valid <= 1'b1;
        vin.in_x <= pending_reqs[0].x;
        vin.in_y <= pending_reqs[0].y;
        vin.in_z <= pending_reqs[0].z;
        vin.angle_x <= pending_reqs[0].ax;
        vin.angle_y <= pending_reqs[0].ay;
        vin.angle_z <= pending_reqs[0].az;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
          gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        vin.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
        if (pending_reqs.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      vout.ready <= 1'b0;
    end else begin
      if (cycle_cnt == 300) hold_cycles <= 150;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      if (hold_cycles > 1 || cycle_cnt == 300) vout.ready <= 1'b0;
      else if ((cycle_cnt / 500) % 2 == 0) vout.ready <= 1'b1;
      else vout.ready <= $urandom_range(0, 3) != 0;
    end
  end

  always @(posedge clk) begin
    erot_pkg::vec_t exp_v;
    if (!rst && vout.valid && vout.ready) begin
      if (expected_vecs.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, vout.out_x, vout.out_y, vout.out_z);
        n_errors++;
      end else begin
        exp_v = expected_vecs.pop_front();
        if (vout.out_x !== exp_v.x) begin
          $display("%0t: out_x expected %h actual %h", $time, exp_v.x, vout.out_x);
          n_errors++;
        end
        if (vout.out_y !== exp_v.y) begin
          $display("%0t: out_y expected %h actual %h", $time, exp_v.y, vout.out_y);
          n_errors++;
        end
        if (vout.out_z !== exp_v.z) begin
          $display("%0t: out_z expected %h actual %h", $time, exp_v.z, vout.out_z);
          n_errors++;
        end
      end
    end
  end

  initial begin
    fork
      begin
        wait (stim_done && expected_vecs.size() == 0);
        repeat (60) @(posedge clk);
      end
      begin
        wait (cycle_cnt == 200000);
      end
    join_any
    if (stim_done && expected_vecs.size() == 0 && n_errors == 0 && cycle_cnt < 200000)
      $display("euler_xyz_vector_rotator: match");
    else
      $display("euler_xyz_vector_rotator: mismatch");
    $finish;
  end
endmodule

>>> filelist.f
src/erot_pkg.sv
src/erot_if.sv
src/euler_xyz_vector_rotator.sv
src/erot_chk.sv
verif/euler_xyz_vector_rotator_test.sv
